// File: src/sttq_pkg.sv
`default_nettype none
package sttq_pkg;

    localparam int TIMER_SLOTS = 16;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);

    // request codes
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_CREATE = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_CALLBACK = 3'd0;
    localparam logic [2:0] KIND_WOKEN    = 3'd1;
    localparam logic [2:0] KIND_CREATED  = 3'd2;
    localparam logic [2:0] KIND_DELETED  = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_NOT_FOUND = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_FLUSH,
        S_CREATE,
        S_DELETE
    } t_state;

    typedef struct packed {
        logic acc_tick;
        logic acc_create;
        logic acc_delete;
        logic err_full;
        logic err_handle;
        logic pos_inc;
        logic found;
        logic remove;
        logic insert;
        logic emit_deleted;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic             at_end;
        logic             due;
        logic             later;
        logic             is_wake;
        logic             sleeping;
        logic             is_handle;
        logic             full;
        logic             handle_ok;
        logic [CNT_W-1:0] count;
    } t_stat;

endpackage
`default_nettype wire

// File: src/sttq_ctrl.sv
`default_nettype none
module sttq_ctrl
    import sttq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        start,
    input  wire  [1:0] i_req_type,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       busy
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    case (i_req_type)
                        REQ_TICK: begin
                            o_cmd.acc_tick = 1'b1;
                            n_state        = S_TICK;
                        end
                        REQ_CREATE: begin
                            if (i_stat.full) begin
                                o_cmd.err_full = 1'b1;
                            end else begin
                                o_cmd.acc_create = 1'b1;
                                n_state          = S_CREATE;
                            end
                        end
                        REQ_DELETE: begin
                            if (!i_stat.handle_ok) begin
                                o_cmd.err_handle = 1'b1;
                            end else begin
                                o_cmd.acc_delete = 1'b1;
                                n_state          = S_DELETE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_TICK: begin
                if (i_stat.at_end || !i_stat.due) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_stat.is_wake) begin
                    if (i_stat.sleeping) begin
                        o_cmd.found  = 1'b1;
                        o_cmd.remove = 1'b1;
                        n_state      = S_FLUSH;
                    end else begin
                        o_cmd.pos_inc = 1'b1;
                    end
                end else begin
                    o_cmd.found   = 1'b1;
                    o_cmd.pos_inc = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            S_CREATE: begin
                if (i_stat.at_end || i_stat.later) begin
                    o_cmd.insert = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                end
            end
            S_DELETE: begin
                if (i_stat.at_end) begin
                    o_cmd.emit_deleted = 1'b1;
                    n_state            = S_IDLE;
                end else if (i_stat.is_handle) begin
                    o_cmd.emit_deleted = 1'b1;
                    o_cmd.remove       = 1'b1;
                    n_state            = S_IDLE;
                end else begin
                    o_cmd.pos_inc = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

// File: src/sttq_dp.sv
`default_nettype none
module sttq_dp
    import sttq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_cmd        i_cmd,
    input  wire  [3:0]  i_handle,
    input  wire  [31:0] i_delay,
    input  wire  [3:0]  i_owner_task,
    input  wire         i_is_wakeup,
    input  wire  [15:0] i_sleeping_mask,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [3:0]  o_task_res,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    logic [63:0]       r_tick;
    logic [63:0]       r_deadline [TIMER_SLOTS];
    logic [3:0]        r_owner    [TIMER_SLOTS];
    logic              r_wake     [TIMER_SLOTS];
    logic [SLOT_W-1:0] r_order    [TIMER_SLOTS];
    logic [TIMER_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_pos;
    logic [15:0]       r_smask;
    logic [63:0]       r_dl;
    logic [SLOT_W-1:0] r_new_slot;
    logic [3:0]        r_new_owner;
    logic              r_new_wake;
    logic [3:0]        r_handle;
    logic              r_pend_v;
    logic [2:0]        r_pend_kind;
    logic [SLOT_W-1:0] r_pend_slot;
    logic [3:0]        r_pend_task;

    logic [SLOT_W-1:0] cur_slot;
    logic [SLOT_W-1:0] free_slot;
    logic [63:0]       cur_dl;

    // entry under the walk pointer
    assign cur_slot = r_order[r_pos[SLOT_W-1:0]];
    assign cur_dl   = r_deadline[cur_slot];

    // lowest free slot
    always_comb begin
        free_slot = '0;
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    // status to the controller
    always_comb begin
        o_stat.at_end    = (r_pos >= r_count);
        o_stat.due       = (cur_dl <= r_tick);
        o_stat.later     = (cur_dl > r_dl);
        o_stat.is_wake   = r_wake[cur_slot];
        o_stat.sleeping  = r_smask[r_owner[cur_slot]];
        o_stat.is_handle = (cur_slot == r_handle[SLOT_W-1:0]);
        o_stat.full      = (r_count == CNT_W'(TIMER_SLOTS));
        o_stat.handle_ok = r_valid[i_handle[SLOT_W-1:0]];
        o_stat.count     = r_count;
    end

    // payload registers: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_tick) begin
            r_smask <= i_sleeping_mask;
        end
        if (i_cmd.acc_create) begin
            r_dl        <= r_tick + {32'b0, i_delay};
            r_new_slot  <= free_slot;
            r_new_owner <= i_owner_task;
            r_new_wake  <= i_is_wakeup;
        end
        if (i_cmd.acc_delete) begin
            r_handle <= i_handle;
        end
        if (i_cmd.found) begin
            r_pend_kind <= r_wake[cur_slot] ? KIND_WOKEN : KIND_CALLBACK;
            r_pend_slot <= cur_slot;
            r_pend_task <= r_owner[cur_slot];
        end
        // close the gap left by a removed entry
        if (i_cmd.remove) begin
            for (int i = 0; i < TIMER_SLOTS - 1; i++) begin
                if (CNT_W'(i) >= r_pos) begin
                    r_order[i] <= r_order[i + 1];
                end
            end
        end
        // open a gap and place the new timer
        if (i_cmd.insert) begin
            for (int i = 1; i < TIMER_SLOTS; i++) begin
                if (CNT_W'(i) > r_pos) begin
                    r_order[i] <= r_order[i - 1];
                end
            end
            r_order[r_pos[SLOT_W-1:0]] <= r_new_slot;
            r_deadline[r_new_slot]     <= r_dl;
            r_owner[r_new_slot]        <= r_new_owner;
            r_wake[r_new_slot]         <= r_new_wake;
        end
        // result transfer
        if (i_cmd.err_full) begin
            o_kind       <= KIND_ERROR;
            o_slot       <= '0;
            o_task_res   <= i_owner_task;
            o_error_code <= ERR_FULL;
            o_last       <= 1'b1;
        end else if (i_cmd.err_handle) begin
            o_kind       <= KIND_ERROR;
            o_slot       <= i_handle;
            o_task_res   <= '0;
            o_error_code <= ERR_NOT_FOUND;
            o_last       <= 1'b1;
        end else if (i_cmd.insert) begin
            o_kind       <= KIND_CREATED;
            o_slot       <= 4'(r_new_slot);
            o_task_res   <= r_new_owner;
            o_error_code <= ERR_NONE;
            o_last       <= 1'b1;
        end else if (i_cmd.emit_deleted) begin
            o_kind       <= KIND_DELETED;
            o_slot       <= r_handle;
            o_task_res   <= r_owner[r_handle[SLOT_W-1:0]];
            o_error_code <= ERR_NONE;
            o_last       <= 1'b1;
        end else if (i_cmd.found || i_cmd.flush) begin
            o_kind       <= r_pend_kind;
            o_slot       <= 4'(r_pend_slot);
            o_task_res   <= r_pend_task;
            o_error_code <= ERR_NONE;
            o_last       <= i_cmd.flush;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_valid  <= '0;
            r_count  <= '0;
            r_pos    <= '0;
            r_pend_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= i_cmd.err_full | i_cmd.err_handle | i_cmd.insert
                     | i_cmd.emit_deleted
                     | ((i_cmd.found | i_cmd.flush) & r_pend_v);
            if (i_cmd.acc_tick) begin
                r_tick   <= r_tick + 64'd1;
                r_pend_v <= 1'b0;
            end
            if (i_cmd.acc_tick || i_cmd.acc_create || i_cmd.acc_delete) begin
                r_pos <= '0;
            end else if (i_cmd.pos_inc) begin
                r_pos <= r_pos + CNT_W'(1);
            end
            if (i_cmd.found) begin
                r_pend_v <= 1'b1;
            end
            if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
            if (i_cmd.remove) begin
                r_valid[cur_slot] <= 1'b0;
                r_count           <= r_count - CNT_W'(1);
            end
            // a delete that found no list entry still frees its slot
            if (i_cmd.emit_deleted && !i_cmd.remove) begin
                r_valid[r_handle[SLOT_W-1:0]] <= 1'b0;
            end
            if (i_cmd.insert) begin
                r_valid[r_new_slot] <= 1'b1;
                r_count             <= r_count + CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

// File: src/sorted_timeout_timer_queue_unit.sv
`default_nettype none
// Sorted timer queue: a 64-bit tick count and up to sixteen timers kept in
// deadline order.
// Requests: drive the request fields and raise start; the transfer happens
// on a clock edge with start high and busy low. Tick (0) advances time and
// walks the expired timers, create (1) adds a timer, delete (2) removes one.
// Results: each appears for one cycle with o_valid high; o_last marks the
// final result of a request. The receiver cannot stall the block.
// Timing: errors come out in the cycle after the transfer with busy staying
// low. Create and delete walk the ordered list one entry a cycle; a tick
// visits the due entries and then releases the last result. A new request
// is taken once busy falls. The walk over the list sets the rate.
// Reset (i_rst_n low, synchronous) clears the tick count and empties the
// table; no results are pending afterwards.
module sorted_timeout_timer_queue_unit
    import sttq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_req_type,
    input  wire  [3:0]  i_handle,
    input  wire  [31:0] i_delay,
    input  wire  [3:0]  i_owner_task,
    input  wire         i_is_wakeup,
    input  wire  [15:0] i_sleeping_mask,
    output logic        o_valid,
    output logic [2:0]  o_kind,
    output logic [3:0]  o_slot,
    output logic [3:0]  o_task_res,
    output logic [1:0]  o_error_code,
    output logic        o_last
);

    t_cmd  cmd;
    t_stat stat;

    // sequencer
    sttq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .busy       (busy)
    );

    // timer table and list
    sttq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_handle        (i_handle),
        .i_delay         (i_delay),
        .i_owner_task    (i_owner_task),
        .i_is_wakeup     (i_is_wakeup),
        .i_sleeping_mask (i_sleeping_mask),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_kind          (o_kind),
        .o_slot          (o_slot),
        .o_task_res      (o_task_res),
        .o_error_code    (o_error_code),
        .o_last          (o_last)
    );

`ifndef NO_ASSERTIONS
    // a result only follows a transfer or work in progress
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without a request");

    // errors are always single results
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_ERROR) |-> o_last)
        else $error("error result not marked last");

    // the list never holds more timers than slots
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.count <= CNT_W'(TIMER_SLOTS))
        else $error("timer count overflow");
`endif

endmodule
`default_nettype wire
